/* rtl/uce_pkg.sv */
// Shared types and constants for the code point encoder.
`timescale 1ns / 1ps
package uce_pkg;

    // Output encoding codes
    localparam logic [1:0] FMT_UTF8  = 2'd0;
    localparam logic [1:0] FMT_UTF16 = 2'd1;
    localparam logic [1:0] FMT_UTF32 = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_ENDIAN = 1'b1;

    // Unicode limits
    localparam logic [31:0] UNI_MAX   = 32'h0010_FFFF;
    localparam logic [31:0] SUR_LO    = 32'h0000_D800;
    localparam logic [31:0] SUR_HI    = 32'h0000_DFFF;
    localparam logic [31:0] PLANE1    = 32'h0001_0000;

    // Classified code point, first stage to second
    typedef struct packed {
        logic [31:0] cp;
        logic [1:0]  fmt;
        logic        le;
        logic        bad;
        logic [1:0]  u8_last;  // UTF-8 byte count minus one
        logic        supp;     // above the basic plane
    } t_cls;

    // Built unit list, second stage to serializer
    typedef struct packed {
        logic [3:0][31:0] unit;
        logic             bad;
        logic [1:0]       last_idx;
    } t_units;

endpackage

/* rtl/unicode_code_point_encoder.sv */
// Each code point is registered by the classify, build and serialize stages in turn, then by the output register.
// Throughput: one code point per cycle when each yields one unit and i_stall is low; a code point with
// n units (UTF-8 up to 4, UTF-16 pair 2) holds the one-unit output register until all n units are sent.
// Reset: synchronous, active low; clears all valid bits, format to UTF-8, big-endian.
// Top level: configuration registers and the classify, build and serialize stages.
`timescale 1ns / 1ps
module unicode_code_point_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_code_point,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_code_unit,
    output logic        o_invalid,
    output logic        o_last_unit
);

    logic [1:0]      r_format;
    logic            r_le;
    logic            w_wr;
    logic            w_reg;
    logic            w_s1_ready;
    logic            w_s1_valid;
    uce_pkg::t_cls   w_cls;
    logic            w_s2_ready;
    logic            w_s2_valid;
    uce_pkg::t_units w_units;
    logic            w_s3_ready;

    // Register file
    assign pready = 1'b1;
    assign w_reg  = paddr[2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= uce_pkg::FMT_UTF8;
            r_le     <= 1'b0;
        end else if (w_wr) begin
            case (w_reg)
                uce_pkg::REG_FORMAT: r_format <= pwdata[1:0];
                uce_pkg::REG_ENDIAN: r_le     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            uce_pkg::REG_FORMAT: prdata = {30'd0, r_format};
            uce_pkg::REG_ENDIAN: prdata = {31'd0, r_le};
            default:             prdata = 32'd0;
        endcase
    end

    assign o_stall = !w_s1_ready;

    uce_classify u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_code_point (i_code_point),
        .i_fmt        (r_format),
        .i_le         (r_le),
        .o_ready      (w_s1_ready),
        .i_ready      (w_s2_ready),
        .o_valid      (w_s1_valid),
        .o_cls        (w_cls)
    );

    uce_build u_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .i_cls   (w_cls),
        .o_ready (w_s2_ready),
        .i_ready (w_s3_ready),
        .o_valid (w_s2_valid),
        .o_units (w_units)
    );

    uce_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_s2_valid),
        .i_units     (w_units),
        .o_ready     (w_s3_ready),
        .o_valid     (o_valid),
        .o_code_unit (o_code_unit),
        .o_invalid   (o_invalid),
        .o_last_unit (o_last_unit),
        .i_stall     (i_stall)
    );

endmodule

/* rtl/uce_classify.sv */
// First stage: range checks and UTF-8 length class of the code point.
`timescale 1ns / 1ps
module uce_classify (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_code_point,
    input  logic [1:0]    i_fmt,
    input  logic          i_le,
    output logic          o_ready,
    input  logic          i_ready,
    output logic          o_valid,
    output uce_pkg::t_cls o_cls
);

    logic          r_valid;
    uce_pkg::t_cls r_cls;
    uce_pkg::t_cls n_cls;
    logic          w_adv;

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    // Classify the incoming beat
    always_comb begin
        n_cls.cp   = i_code_point;
        n_cls.fmt  = i_fmt;
        n_cls.le   = i_le;
        n_cls.bad  = (i_code_point > uce_pkg::UNI_MAX) ||
                     ((i_code_point >= uce_pkg::SUR_LO) &&
                      (i_code_point <= uce_pkg::SUR_HI));
        n_cls.supp = (i_code_point >= uce_pkg::PLANE1);
        if (i_code_point <= 32'h0000_007F) begin
            n_cls.u8_last = 2'd0;
        end else if (i_code_point <= 32'h0000_07FF) begin
            n_cls.u8_last = 2'd1;
        end else if (i_code_point <= 32'h0000_FFFF) begin
            n_cls.u8_last = 2'd2;
        end else begin
            n_cls.u8_last = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_cls <= n_cls;
            end
        end
    end

endmodule

/* rtl/uce_build.sv */
// Second stage: forms every code unit of one code point, with byte order applied to UTF-16 and UTF-32 units.
`timescale 1ns / 1ps
module uce_build (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  uce_pkg::t_cls   i_cls,
    output logic            o_ready,
    input  logic            i_ready,
    output logic            o_valid,
    output uce_pkg::t_units o_units
);

    logic            r_valid;
    uce_pkg::t_units r_units;
    uce_pkg::t_units n_units;
    logic            w_adv;
    logic [20:0]     w_off;
    logic [15:0]     w_hi;
    logic [15:0]     w_lo;
    logic [31:0]     w_cp;

    function automatic logic [31:0] swap16(input logic [31:0] v);
        return {16'h0000, v[7:0], v[15:8]};
    endfunction

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_valid;
    assign o_units = r_units;
    assign w_cp    = i_cls.cp;

    // Surrogate pair halves
    assign w_off = w_cp[20:0] - 21'h01_0000;
    assign w_hi  = 16'hD800 | {6'd0, w_off[19:10]};
    assign w_lo  = 16'hDC00 | {6'd0, w_off[9:0]};

    always_comb begin
        n_units.unit     = '0;
        n_units.bad      = i_cls.bad;
        n_units.last_idx = 2'd0;
        case (i_cls.fmt)
            uce_pkg::FMT_UTF8: begin
                if (i_cls.bad) begin
                    n_units.unit[0] = w_cp;
                end else begin
                    n_units.last_idx = i_cls.u8_last;
                    case (i_cls.u8_last)
                        2'd0: begin
                            n_units.unit[0] = w_cp;
                        end
                        2'd1: begin
                            n_units.unit[0] = {24'd0, 3'b110, w_cp[10:6]};
                            n_units.unit[1] = {24'd0, 2'b10, w_cp[5:0]};
                        end
                        2'd2: begin
                            n_units.unit[0] = {24'd0, 4'b1110, w_cp[15:12]};
                            n_units.unit[1] = {24'd0, 2'b10, w_cp[11:6]};
                            n_units.unit[2] = {24'd0, 2'b10, w_cp[5:0]};
                        end
                        default: begin
                            n_units.unit[0] = {24'd0, 5'b11110, w_cp[20:18]};
                            n_units.unit[1] = {24'd0, 2'b10, w_cp[17:12]};
                            n_units.unit[2] = {24'd0, 2'b10, w_cp[11:6]};
                            n_units.unit[3] = {24'd0, 2'b10, w_cp[5:0]};
                        end
                    endcase
                end
            end
            uce_pkg::FMT_UTF16: begin
                if (i_cls.bad || !i_cls.supp) begin
                    n_units.unit[0] = i_cls.le ? swap16(w_cp) : w_cp;
                end else begin
                    n_units.last_idx = 2'd1;
                    n_units.unit[0]  = i_cls.le ? swap16({16'd0, w_hi}) : {16'd0, w_hi};
                    n_units.unit[1]  = i_cls.le ? swap16({16'd0, w_lo}) : {16'd0, w_lo};
                end
            end
            default: begin
                // UTF-32, and the unused format code
                n_units.unit[0] = i_cls.le ? swap32(w_cp) : w_cp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_units <= n_units;
            end
        end
    end

endmodule

/* rtl/uce_serial.sv */
// Third stage: sends the units of one code point one beat at a time.
`timescale 1ns / 1ps
module uce_serial (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  uce_pkg::t_units i_units,
    output logic            o_ready,
    output logic            o_valid,
    output logic [31:0]     o_code_unit,
    output logic            o_invalid,
    output logic            o_last_unit,
    input  logic            i_stall
);

    logic             r_busy;
    logic [3:0][31:0] r_unit;
    logic             r_bad;
    logic [1:0]       r_left;
    logic             r_out_valid;
    logic [31:0]      r_code_unit;
    logic             r_invalid;
    logic             r_last;
    logic             w_out_load;
    logic             w_take;

    // Output register loads when empty or when its beat is taken
    assign w_out_load = !r_out_valid || !i_stall;
    assign o_ready    = !r_busy || (w_out_load && (r_left == 2'd0));
    assign w_take     = i_valid && o_ready;

    assign o_valid     = r_out_valid;
    assign o_code_unit = r_code_unit;
    assign o_invalid   = r_invalid;
    assign o_last_unit = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Present the front unit
            if (w_out_load) begin
                r_out_valid <= r_busy;
                if (r_busy) begin
                    r_code_unit <= r_unit[0];
                    r_invalid   <= r_bad;
                    r_last      <= (r_left == 2'd0);
                end
            end
            // Load a new item or shift to the next unit
            if (w_take) begin
                r_busy <= 1'b1;
                r_unit <= i_units.unit;
                r_bad  <= i_units.bad;
                r_left <= i_units.last_idx;
            end else if (w_out_load && r_busy) begin
                if (r_left == 2'd0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_unit <= {32'd0, r_unit[3:1]};
                    r_left <= r_left - 2'd1;
                end
            end
        end
    end

endmodule
